FILE: design/qvr_pkg.sv
// qvr_pkg: widths, fixed-point constants and data types for the quaternion
// vector rotation core
// no dependencies
`default_nettype none

package qvr_pkg;

  // field widths
  localparam int VEC_W          = 32;
  localparam int QUAT_W         = 18;
  localparam int QUAT_FRAC_BITS = 15;

  // stream bus widths
  localparam int IN_TDATA_W  = 3 * VEC_W + 4 * QUAT_W;
  localparam int OUT_TDATA_W = 3 * VEC_W;

  // pipeline depth, output register included
  localparam int NUM_STAGES = 6;

  // quaternion products and rotation matrix entries
  localparam int PROD_W = 2 * QUAT_W;
  localparam int MAT_W  = PROD_W + 2;

  // matrix entry split for the partial products
  localparam int LO_W      = MAT_W / 2;
  localparam int HI_W      = MAT_W - LO_W;
  localparam int LPROD_W   = LO_W + 1 + VEC_W;
  localparam int HPROD_W   = HI_W + VEC_W;
  localparam int LSUM_W    = LPROD_W + 2;
  localparam int HSUM_W    = HPROD_W + 2;
  localparam int ACC_W     = HSUM_W + LO_W + 1;

  // rounding
  localparam int RND_SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int SHR_W     = ACC_W - RND_SHIFT;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [QUAT_W-1:0]  quat_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [MAT_W-1:0]   mat_t;
  typedef logic signed [LPROD_W-1:0] lprod_t;
  typedef logic signed [HPROD_W-1:0] hprod_t;
  typedef logic signed [LSUM_W-1:0]  lsum_t;
  typedef logic signed [HSUM_W-1:0]  hsum_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [SHR_W-1:0]   shr_t;

  localparam acc_t RND_HALF = acc_t'(1) <<< (RND_SHIFT - 1);
  localparam vec_t VEC_MAX  = {1'b0, {(VEC_W-1){1'b1}}};
  localparam vec_t VEC_MIN  = {1'b1, {(VEC_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: design/quaternion_vector_rotate_core.sv
// quaternion_vector_rotate_core: streaming rotation of a Q16.16 vector by a
// Q3.15 quaternion, six register stages
// depends on qvr_pkg
`default_nettype none

// Rotates a 3D vector v by a quaternion q as q v q*, in expanded matrix form.
// q is not normalised, so the result is also scaled by w^2 + x^2 + y^2 + z^2.
// Each output component is formed exactly at full width, rounded to nearest
// with ties toward plus infinity and saturated to 32 bits; out_tuser flags a
// clip on any component. Throughput is one transfer per clock with no gaps
// while out_tready is high; an input transfer reaches the output register
// through the chain quaternion products, matrix assembly, split 20x32 and
// 19x32 partial products, partial sums, final add with rounding, and
// saturation. Each stage holds its item while the next one is full and cannot
// move on, so a stall on the output back-pressures the input only once all six
// stages are occupied, and no transfer is lost or repeated.
module quaternion_vector_rotate_core
  import qvr_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z (lowest bit up)
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // rot_x, rot_y, rot_z (lowest bit up)
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // saturated
  output logic                        out_tuser
);

  // ---------------------------------------------------------------------
  // stage valid bits and per-stage enables
  // ---------------------------------------------------------------------
  logic [NUM_STAGES-1:0] v_r, v_nxt;
  logic [NUM_STAGES-1:0] en;

  // a stage may load when it is empty or its item moves on this cycle
  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[NUM_STAGES-1];

  // ---------------------------------------------------------------------
  // input unpacking
  // ---------------------------------------------------------------------
  vec_t  in_vec [3];
  quat_t qw, qx, qy, qz;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      in_vec[c] = vec_t'(in_tdata[c*VEC_W +: VEC_W]);
    end
    qw = quat_t'(in_tdata[3*VEC_W +: QUAT_W]);
    qx = quat_t'(in_tdata[3*VEC_W + QUAT_W +: QUAT_W]);
    qy = quat_t'(in_tdata[3*VEC_W + 2*QUAT_W +: QUAT_W]);
    qz = quat_t'(in_tdata[3*VEC_W + 3*QUAT_W +: QUAT_W]);
  end

  // ---------------------------------------------------------------------
  // stage 1: the ten quaternion products
  // ---------------------------------------------------------------------
  prod_t ww_r, xx_r, yy_r, zz_r, wx_r, wy_r, wz_r, xy_r, xz_r, yz_r;
  prod_t ww_nxt, xx_nxt, yy_nxt, zz_nxt, wx_nxt, wy_nxt, wz_nxt;
  prod_t xy_nxt, xz_nxt, yz_nxt;
  vec_t  s1_vec_r [3];

  always_comb begin
    ww_nxt = qw * qw;
    xx_nxt = qx * qx;
    yy_nxt = qy * qy;
    zz_nxt = qz * qz;
    wx_nxt = qw * qx;
    wy_nxt = qw * qy;
    wz_nxt = qw * qz;
    xy_nxt = qx * qy;
    xz_nxt = qx * qz;
    yz_nxt = qy * qz;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ww_r <= ww_nxt;
      xx_r <= xx_nxt;
      yy_r <= yy_nxt;
      zz_r <= zz_nxt;
      wx_r <= wx_nxt;
      wy_r <= wy_nxt;
      wz_r <= wz_nxt;
      xy_r <= xy_nxt;
      xz_r <= xz_nxt;
      yz_r <= yz_nxt;
      s1_vec_r <= in_vec;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: rotation matrix, row-major, entries at 2*QUAT_FRAC_BITS
  // ---------------------------------------------------------------------
  mat_t m_r [9];
  mat_t m_nxt [9];
  vec_t s2_vec_r [3];

  always_comb begin
    // diagonal
    m_nxt[0] = mat_t'(ww_r) + mat_t'(xx_r) - mat_t'(yy_r) - mat_t'(zz_r);
    m_nxt[4] = mat_t'(ww_r) - mat_t'(xx_r) + mat_t'(yy_r) - mat_t'(zz_r);
    m_nxt[8] = mat_t'(ww_r) - mat_t'(xx_r) - mat_t'(yy_r) + mat_t'(zz_r);
    // off-diagonal, doubled
    m_nxt[1] = (mat_t'(xy_r) - mat_t'(wz_r)) <<< 1;
    m_nxt[2] = (mat_t'(wy_r) + mat_t'(xz_r)) <<< 1;
    m_nxt[3] = (mat_t'(xy_r) + mat_t'(wz_r)) <<< 1;
    m_nxt[5] = (mat_t'(yz_r) - mat_t'(wx_r)) <<< 1;
    m_nxt[6] = (mat_t'(xz_r) - mat_t'(wy_r)) <<< 1;
    m_nxt[7] = (mat_t'(yz_r) + mat_t'(wx_r)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m_r      <= m_nxt;
      s2_vec_r <= s1_vec_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: each entry split into a low unsigned and a high signed half,
  // each half multiplied by its vector component
  // ---------------------------------------------------------------------
  lprod_t plo_r [9];
  hprod_t phi_r [9];
  lprod_t plo_nxt [9];
  hprod_t phi_nxt [9];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        plo_nxt[r*3+c] = $signed({1'b0, m_r[r*3+c][LO_W-1:0]}) * s2_vec_r[c];
        phi_nxt[r*3+c] = $signed(m_r[r*3+c][MAT_W-1:LO_W]) * s2_vec_r[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: per-row sums of the low and high partial products
  // ---------------------------------------------------------------------
  lsum_t lsum_r [3];
  hsum_t hsum_r [3];
  lsum_t lsum_nxt [3];
  hsum_t hsum_nxt [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      lsum_nxt[r] = lsum_t'(plo_r[r*3]) + lsum_t'(plo_r[r*3+1])
                  + lsum_t'(plo_r[r*3+2]);
      hsum_nxt[r] = hsum_t'(phi_r[r*3]) + hsum_t'(phi_r[r*3+1])
                  + hsum_t'(phi_r[r*3+2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lsum_r <= lsum_nxt;
      hsum_r <= hsum_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: full-width row value plus the rounding half
  // ---------------------------------------------------------------------
  acc_t acc_r [3];
  acc_t acc_nxt [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = (acc_t'(hsum_r[r]) <<< LO_W) + acc_t'(lsum_r[r]) + RND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      acc_r <= acc_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 6: drop the fraction bits, saturate, output register
  // ---------------------------------------------------------------------
  vec_t rot_r [3];
  vec_t rot_nxt [3];
  logic sat_r, sat_nxt;
  shr_t shr [3];
  logic [2:0] clip;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shr[r] = shr_t'(acc_r[r][ACC_W-1:RND_SHIFT]);
      // in range when every bit from the result sign upward agrees
      clip[r] = !((&shr[r][SHR_W-1:VEC_W-1]) || !(|shr[r][SHR_W-1:VEC_W-1]));
      if (!clip[r]) begin
        rot_nxt[r] = vec_t'(shr[r][VEC_W-1:0]);
      end else if (shr[r][SHR_W-1]) begin
        rot_nxt[r] = VEC_MIN;
      end else begin
        rot_nxt[r] = VEC_MAX;
      end
    end
    sat_nxt = |clip;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rot_r <= rot_nxt;
      sat_r <= sat_nxt;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      out_tdata[r*VEC_W +: VEC_W] = rot_r[r];
    end
  end

  assign out_tuser = sat_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------

  // an accepted transfer always lands in the first stage
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v_r[0])
    else $error("accepted input transfer not captured in stage 1");

  // a blocked first stage keeps its item
  assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !en[0] |=> v_r[0])
    else $error("stalled item dropped from stage 1");

  // a clipped result carries at least one limit value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      rot_r[0] == VEC_MAX || rot_r[0] == VEC_MIN ||
      rot_r[1] == VEC_MAX || rot_r[1] == VEC_MIN ||
      rot_r[2] == VEC_MAX || rot_r[2] == VEC_MIN)
    else $error("saturation flag without a clipped component");

endmodule

`default_nettype wire

FILE: test/quaternion_vector_rotate_core_test.sv
// quaternion_vector_rotate_core_test: self-checking bench for the quaternion vector rotation core
// drives random and directed stream transfers and checks every result against typed-in values or its own predictor
// depends on qvr_pkg and quaternion_vector_rotate_core
`timescale 1ns / 100ps

module quaternion_vector_rotate_core_test;
  import qvr_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int HANG_LIMIT = 2000;
  // random items per idling phase, three phases in all
  localparam int ITEMS_PER_PHASE = 470;

  localparam quat_t Q_MAX = {1'b0, {(QUAT_W-1){1'b1}}};
  localparam quat_t Q_MIN = {1'b1, {(QUAT_W-1){1'b0}}};
  // 1.0 in quaternion format
  localparam quat_t Q_ONE = quat_t'(1) <<< QUAT_FRAC_BITS;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    vec_t  vx;
    vec_t  vy;
    vec_t  vz;
    quat_t qw;
    quat_t qx;
    quat_t qy;
    quat_t qz;
  } rot_item_t;

  typedef struct packed {
    vec_t rx;
    vec_t ry;
    vec_t rz;
    logic sat;
  } rot_result_t;

  // one row of the directed table; known marks a typed-in expectation
  typedef struct packed {
    rot_item_t   item;
    logic        known;
    rot_result_t res;
  } rot_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  rot_result_t expected_rot_q[$];
  rot_row_t    directed_rows[$];
  int          mismatch_count = 0;
  int          sender_idle_pct = 32;
  int          recv_idle_pct = 71;
  int          quiet_cycles = 0;

  quaternion_vector_rotate_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z (lowest bit up)
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // rot_x, rot_y, rot_z (lowest bit up)
    .out_tdata  (out_tdata),
    // saturated
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // rotated vector q v q*, exact sums, round half up, clip to 32 bits
  function automatic rot_result_t rotate_vector(rot_item_t it);
    longint      ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
    longint      mat [3][3];
    vec_t        v [3];
    vec_t        r [3];
    wide_t       acc;
    wide_t       shifted;
    rot_result_t res;
    ww = longint'(it.qw) * longint'(it.qw);
    xx = longint'(it.qx) * longint'(it.qx);
    yy = longint'(it.qy) * longint'(it.qy);
    zz = longint'(it.qz) * longint'(it.qz);
    wx = longint'(it.qw) * longint'(it.qx);
    wy = longint'(it.qw) * longint'(it.qy);
    wz = longint'(it.qw) * longint'(it.qz);
    xy = longint'(it.qx) * longint'(it.qy);
    xz = longint'(it.qx) * longint'(it.qz);
    yz = longint'(it.qy) * longint'(it.qz);
    // rotation matrix, entries carry twice the quaternion fraction bits
    mat[0][0] = ww + xx - yy - zz;
    mat[0][1] = 2 * (xy - wz);
    mat[0][2] = 2 * (wy + xz);
    mat[1][0] = 2 * (xy + wz);
    mat[1][1] = ww - xx + yy - zz;
    mat[1][2] = 2 * (yz - wx);
    mat[2][0] = 2 * (xz - wy);
    mat[2][1] = 2 * (yz + wx);
    mat[2][2] = ww - xx - yy + zz;
    v[0] = it.vx;
    v[1] = it.vy;
    v[2] = it.vz;
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = '0;
      for (int k = 0; k < 3; k++) begin
        acc = acc + wide_t'(mat[i][k]) * wide_t'(v[k]);
      end
      acc = acc + (wide_t'(1) <<< (2 * QUAT_FRAC_BITS - 1));
      shifted = acc >>> (2 * QUAT_FRAC_BITS);
      if (shifted > wide_t'(VEC_MAX)) begin
        r[i] = VEC_MAX;
        res.sat = 1'b1;
      end else if (shifted < wide_t'(VEC_MIN)) begin
        r[i] = VEC_MIN;
        res.sat = 1'b1;
      end else begin
        r[i] = vec_t'(shifted);
      end
    end
    res.rx = r[0];
    res.ry = r[1];
    res.rz = r[2];
    return res;
  endfunction

  function automatic void add_row(vec_t vx, vec_t vy, vec_t vz,
                                  quat_t qw, quat_t qx, quat_t qy, quat_t qz,
                                  logic known, vec_t ex, vec_t ey, vec_t ez, logic es);
    rot_row_t row;
    row.item  = '{vx, vy, vz, qw, qx, qy, qz};
    row.known = known;
    row.res   = '{ex, ey, ez, es};
    directed_rows = {directed_rows, row};
  endfunction

  // mostly full-width random values, with mid-range values and the extremes mixed in
  function automatic vec_t rand_vec_component();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        return VEC_MAX;
      end
      1: begin
        return VEC_MIN;
      end
      2, 3, 4: begin
        return vec_t'($urandom_range(0, 32'h0040_0000)) - vec_t'(32'h0020_0000);
      end
      default: begin
        return vec_t'($urandom);
      end
    endcase
  endfunction

  function automatic quat_t rand_quat_component();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      end
      1, 2, 3, 4, 5: begin
        // within plus or minus 1.0, the usual unit quaternion range
        return quat_t'($urandom_range(0, 2 * 32768)) - Q_ONE;
      end
      default: begin
        return quat_t'($urandom);
      end
    endcase
  endfunction

  function automatic rot_item_t rand_rotation_item();
    rot_item_t it;
    it.vx = rand_vec_component();
    it.vy = rand_vec_component();
    it.vz = rand_vec_component();
    it.qw = rand_quat_component();
    it.qx = rand_quat_component();
    it.qy = rand_quat_component();
    it.qz = rand_quat_component();
    // occasional zero quaternion
    if ($urandom_range(0, 49) == 0) begin
      it.qw = '0;
      it.qx = '0;
      it.qy = '0;
      it.qz = '0;
    end
    return it;
  endfunction

  // one input transfer; the expectation is queued once the transfer is taken
  task automatic send_vector(rot_item_t it, rot_result_t want);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.qz, it.qy, it.qx, it.qw, it.vz, it.vy, it.vx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_rot_q = {expected_rot_q, want};
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: check each transfer in order, then pick the next ready level
  always @(posedge clk) begin : result_check
    rot_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_rot_q.size() == 0) begin
        $display("%0t: unexpected result transfer, expected none, actual %h/%b",
                 $time, out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        want = expected_rot_q.pop_front();
        check_field("rot_x", want.rx, out_tdata[VEC_W-1:0]);
        check_field("rot_y", want.ry, out_tdata[2*VEC_W-1:VEC_W]);
        check_field("rot_z", want.rz, out_tdata[3*VEC_W-1:2*VEC_W]);
        check_field("saturated", 32'(want.sat), 32'(out_tuser));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // hang detection: counts cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rot_item_t it;

    // zero quaternion gives zero whatever the vector
    add_row(0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0);
    add_row(VEC_MAX, VEC_MIN, VEC_MIN, 0, 0, 0, 0, 1'b1, 0, 0, 0, 1'b0);
    // identity quaternion leaves the vector as it is
    add_row(1, -1, VEC_MAX, Q_ONE, 0, 0, 0, 1'b1, 1, -1, VEC_MAX, 1'b0);
    add_row(VEC_MIN, 0, 123456, Q_ONE, 0, 0, 0, 1'b1, VEC_MIN, 0, 123456, 1'b0);
    // w of -4.0 scales by 16, clipping both ways
    add_row(VEC_MAX, VEC_MIN, 0, Q_MIN, 0, 0, 0, 1'b1, VEC_MAX, VEC_MIN, 0, 1'b1);
    // half turns about each axis
    add_row(5, 7, -9, 0, Q_ONE, 0, 0, 1'b1, 5, -7, 9, 1'b0);
    add_row(0, VEC_MIN, 0, 0, Q_ONE, 0, 0, 1'b1, 0, VEC_MAX, 0, 1'b1);
    add_row(VEC_MAX, 3, VEC_MIN, 0, 0, Q_ONE, 0, 1'b1, VEC_MIN + 1, 3, VEC_MAX, 1'b1);
    add_row(10, 20, 30, 0, 0, 0, Q_ONE, 1'b1, -10, -20, 30, 1'b0);
    // tiny scale: exact halves round up, just below a half rounds down
    add_row(32'sd536870912, -32'sd536870912, -32'sd536870913, 1, 0, 0, 0,
            1'b1, 1, 0, -1, 1'b0);
    // predictor rows: extremes and bit patterns of every field
    add_row(VEC_MAX, VEC_MAX, VEC_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0, 0, 0, 0, 1'b0);
    add_row(VEC_MIN, VEC_MAX, VEC_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0, 0, 0, 0, 1'b0);
    add_row(1, -1, 1, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0, 0, 0, 0, 1'b0);
    add_row(32'shAAAAAAAA, 32'sh55555555, 32'shAAAAAAAA,
            18'sh2AAAA, 18'sh15555, 18'sh2AAAA, 18'sh15555, 1'b0, 0, 0, 0, 1'b0);
    add_row(32'sh55555555, 32'shAAAAAAAA, 32'sh55555555,
            18'sh15555, 18'sh2AAAA, 18'sh15555, 18'sh2AAAA, 1'b0, 0, 0, 0, 1'b0);
    // near-unit quarter turn about x
    add_row(65536, 65536, 65536, 23170, 23170, 0, 0, 1'b0, 0, 0, 0, 1'b0);
    add_row(-65536, 131072, 0, 16384, 16384, 16384, 16384, 1'b0, 0, 0, 0, 1'b0);
    add_row(VEC_MIN, VEC_MIN, VEC_MIN, -1, -1, -1, -1, 1'b0, 0, 0, 0, 1'b0);

    // hold reset, then release it
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, under the first idling mix
    foreach (directed_rows[i]) begin
      send_vector(directed_rows[i].item,
                  directed_rows[i].known ? directed_rows[i].res
                                         : rotate_vector(directed_rows[i].item));
    end

    // random part: sender light and receiver heavy, then swapped, then no idling
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 32;
          recv_idle_pct   = 71;
        end
        1: begin
          sender_idle_pct = 71;
          recv_idle_pct   = 32;
        end
        default: begin
          sender_idle_pct = 0;
          recv_idle_pct   = 0;
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        it = rand_rotation_item();
        send_vector(it, rotate_vector(it));
      end
    end
    in_tvalid <= 1'b0;

    // drain, then allow for any stray result behind the pipeline
    while (expected_rot_q.size() != 0) @(posedge clk);
    repeat (4 * NUM_STAGES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
design/qvr_pkg.sv
design/quaternion_vector_rotate_core.sv
test/quaternion_vector_rotate_core_test.sv
